[design/dlg_pkg.sv]
`default_nettype none

package dlg_pkg;

    localparam int FREQ_W    = 22;
    localparam int VOLT_W    = 11;
    localparam int CNT_W     = 32;
    localparam int GOV_W     = 3;
    localparam int LOAD_W    = 7;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    // multiplier: frequency operand times a small factor (load or voltage span)
    localparam int MUL_B_W    = 9;
    localparam int PROD_W     = FREQ_W + MUL_B_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // divide by 100 as a multiply by ceil(2^36 / 100), exact for dividends below 2^29
    localparam int IQ_IN_W     = FREQ_W + LOAD_W;
    localparam int RECIP_W     = 30;
    localparam int IQ_PROD_W   = IQ_IN_W + RECIP_W;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_100 = 30'd687194768;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOV  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREQ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam logic [GOV_W-1:0] GOV_PERF     = 3'd0;
    localparam logic [GOV_W-1:0] GOV_SAVE     = 3'd1;
    localparam logic [GOV_W-1:0] GOV_ONDEMAND = 3'd2;
    localparam logic [GOV_W-1:0] GOV_LAST     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 1'b1;

    localparam logic [LOAD_W-1:0]  LOAD_HI    = 7'd75;
    localparam logic [LOAD_W-1:0]  LOAD_LO    = 7'd25;
    localparam logic [VOLT_W-1:0]  VOLT_BASE  = 11'd850;
    localparam logic [MUL_B_W-1:0] VOLT_SPAN  = 9'd350;

    localparam logic [FREQ_W-1:0] RST_FREQ     = 22'd2400000;
    localparam logic [VOLT_W-1:0] RST_VOLT     = 11'd1050;
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ = 22'd800000;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ = 22'd3600000;
    localparam logic [CNT_W-1:0]  RST_COUNT    = 32'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_IMUL,
        S_IDIV,
        S_IADD,
        S_APPLY,
        S_VMUL,
        S_VDSTART,
        S_VDWAIT,
        S_VOLT,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

[design/dlg_div.sv]
`default_nettype none

module dlg_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [dlg_pkg::PROD_W-1:0]       num,
    input  wire logic [dlg_pkg::FREQ_W-1:0]       den,
    output logic                                  done,
    output logic [dlg_pkg::PROD_W-1:0]            quot
);

    logic [dlg_pkg::PROD_W-1:0]    num_reg, num_next;
    logic [dlg_pkg::FREQ_W-1:0]    rem_reg, rem_next;
    logic [dlg_pkg::FREQ_W-1:0]    den_reg;
    logic [dlg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [dlg_pkg::FREQ_W:0]      shifted;
    logic [dlg_pkg::FREQ_W:0]      diff;
    logic                          fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted   = {rem_reg, num_reg[dlg_pkg::PROD_W-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            num_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[dlg_pkg::FREQ_W-1:0] : shifted[dlg_pkg::FREQ_W-1:0];
            num_next = {num_reg[dlg_pkg::PROD_W-2:0], fits};
            cnt_next = cnt_reg + dlg_pkg::DIV_CNT_W'(1);
            if (cnt_reg == dlg_pkg::DIV_CNT_W'(dlg_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

`default_nettype wire

[design/dvfs_load_governor_unit.sv]
`default_nettype none
// Steps: a command that applies no frequency runs decode then output; a command that applies
// a frequency without a voltage recompute adds an apply step; interpolation adds multiply,
// reciprocal multiply for the divide by 100, and add; a voltage recompute adds multiply,
// divider start, 31 restoring steps, done and the voltage write.
// Throughput: one command at a time, next word taken the cycle after the result loads.
// Reset (aresetn low, synchronous): 2400000 kHz, 1050 mV, count 1, ondemand, 800000..3600000.

module dvfs_load_governor_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dlg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dlg_pkg::FREQ_W-1:0]         cfg_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [dlg_pkg::CMD_W-1:0]          s_cmd,
    input  wire logic [dlg_pkg::LOAD_W-1:0]         s_load_percent,
    input  wire logic [dlg_pkg::GOV_W-1:0]          s_governor_req,
    input  wire logic [dlg_pkg::FREQ_W-1:0]         s_target_freq_khz,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [dlg_pkg::FREQ_W-1:0]              m_freq_khz,
    output logic [dlg_pkg::VOLT_W-1:0]              m_volt_mv,
    output logic [dlg_pkg::CNT_W-1:0]               m_change_count,
    output logic [dlg_pkg::GOV_W-1:0]               m_active_governor,
    output logic                                    m_status
);

    dlg_pkg::state_t state_reg, state_next;

    logic [dlg_pkg::FREQ_W-1:0] min_reg, max_reg;
    logic [dlg_pkg::FREQ_W-1:0] cur_freq_reg, cur_freq_next;
    logic [dlg_pkg::VOLT_W-1:0] cur_volt_reg, cur_volt_next;
    logic [dlg_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dlg_pkg::GOV_W-1:0]  gov_reg, gov_next;
    logic                       status_reg, status_next;
    logic                       m_valid_reg, m_valid_next;

    logic [dlg_pkg::CMD_W-1:0]  cmd_reg;
    logic [dlg_pkg::LOAD_W-1:0] load_reg;
    logic [dlg_pkg::GOV_W-1:0]  greq_reg;
    logic [dlg_pkg::FREQ_W-1:0] target_reg;
    logic [dlg_pkg::FREQ_W-1:0] tgt_reg, tgt_next;
    logic [dlg_pkg::PROD_W-1:0] prod_reg;
    logic [dlg_pkg::FREQ_W-1:0] iq_reg;

    logic [dlg_pkg::FREQ_W-1:0] m_freq_reg;
    logic [dlg_pkg::VOLT_W-1:0] m_volt_reg;
    logic [dlg_pkg::CNT_W-1:0]  m_count_reg;
    logic [dlg_pkg::GOV_W-1:0]  m_gov_reg;
    logic                       m_status_reg;

    logic                          in_accept;
    logic                          out_load;
    logic                          range_ok;
    logic [dlg_pkg::FREQ_W-1:0]    span;
    logic [dlg_pkg::FREQ_W-1:0]    clamp_lo;
    logic [dlg_pkg::FREQ_W-1:0]    clamped;
    logic [dlg_pkg::FREQ_W-1:0]    mul_a;
    logic [dlg_pkg::MUL_B_W-1:0]   mul_b;
    logic [dlg_pkg::PROD_W-1:0]    mul_p;
    logic [dlg_pkg::IQ_PROD_W-1:0] iq_prod;
    logic                          div_start;
    logic                          div_done;
    logic [dlg_pkg::PROD_W-1:0]    div_quot;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == dlg_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    assign range_ok = (max_reg > min_reg);
    assign span     = range_ok ? (max_reg - min_reg) : '0;
    // low bound first, then high bound: an inverted range lands on max
    assign clamp_lo = (tgt_reg < min_reg) ? min_reg : tgt_reg;
    assign clamped  = (clamp_lo > max_reg) ? max_reg : clamp_lo;

    // shared multiplier: load interpolation or voltage numerator
    always_comb begin
        if (state_reg == dlg_pkg::S_IMUL) begin
            mul_a = span;
            mul_b = dlg_pkg::MUL_B_W'(load_reg);
        end else begin
            mul_a = tgt_reg - min_reg;
            mul_b = dlg_pkg::VOLT_SPAN;
        end
        mul_p = dlg_pkg::PROD_W'(mul_a) * dlg_pkg::PROD_W'(mul_b);
    end

    // span times load over 100: keep the high bits of the reciprocal product
    assign iq_prod = dlg_pkg::IQ_PROD_W'(prod_reg[dlg_pkg::IQ_IN_W-1:0])
                   * dlg_pkg::IQ_PROD_W'(dlg_pkg::RECIP_100);

    assign div_start = (state_reg == dlg_pkg::S_VDSTART);

    dlg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (span),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        cur_freq_next = cur_freq_reg;
        cur_volt_next = cur_volt_reg;
        count_next    = count_reg;
        gov_next      = gov_reg;
        status_next   = status_reg;
        tgt_next      = tgt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_load      = 1'b0;
        unique case (state_reg)
            dlg_pkg::S_IDLE: begin
                if (s_valid) begin
                    status_next = 1'b0;
                    state_next  = dlg_pkg::S_DECODE;
                end
            end
            dlg_pkg::S_DECODE: begin
                unique case (cmd_reg)
                    dlg_pkg::CMD_LOAD: begin
                        if (gov_reg != dlg_pkg::GOV_ONDEMAND) begin
                            state_next = dlg_pkg::S_OUT;
                        end else if (load_reg > dlg_pkg::LOAD_HI) begin
                            tgt_next   = max_reg;
                            state_next = dlg_pkg::S_APPLY;
                        end else if (load_reg < dlg_pkg::LOAD_LO) begin
                            tgt_next   = min_reg;
                            state_next = dlg_pkg::S_APPLY;
                        end else begin
                            state_next = dlg_pkg::S_IMUL;
                        end
                    end
                    dlg_pkg::CMD_GOV: begin
                        if (greq_reg > dlg_pkg::GOV_LAST) begin
                            status_next = 1'b1;
                            state_next  = dlg_pkg::S_OUT;
                        end else begin
                            gov_next = greq_reg;
                            if (greq_reg == dlg_pkg::GOV_PERF) begin
                                tgt_next   = max_reg;
                                state_next = dlg_pkg::S_APPLY;
                            end else if (greq_reg == dlg_pkg::GOV_SAVE) begin
                                tgt_next   = min_reg;
                                state_next = dlg_pkg::S_APPLY;
                            end else begin
                                state_next = dlg_pkg::S_OUT;
                            end
                        end
                    end
                    dlg_pkg::CMD_FREQ: begin
                        tgt_next   = target_reg;
                        state_next = dlg_pkg::S_APPLY;
                    end
                    dlg_pkg::CMD_NONE: begin
                        state_next = dlg_pkg::S_OUT;
                    end
                endcase
            end
            dlg_pkg::S_IMUL: state_next = dlg_pkg::S_IDIV;
            dlg_pkg::S_IDIV: state_next = dlg_pkg::S_IADD;
            dlg_pkg::S_IADD: begin
                tgt_next   = min_reg + iq_reg;
                state_next = dlg_pkg::S_APPLY;
            end
            dlg_pkg::S_APPLY: begin
                if (clamped != cur_freq_reg) begin
                    cur_freq_next = clamped;
                    count_next    = count_reg + dlg_pkg::CNT_W'(1);
                    tgt_next      = clamped;
                    if (range_ok) begin
                        state_next = dlg_pkg::S_VMUL;
                    end else begin
                        cur_volt_next = dlg_pkg::VOLT_BASE;
                        state_next    = dlg_pkg::S_OUT;
                    end
                end else begin
                    state_next = dlg_pkg::S_OUT;
                end
            end
            dlg_pkg::S_VMUL:    state_next = dlg_pkg::S_VDSTART;
            dlg_pkg::S_VDSTART: state_next = dlg_pkg::S_VDWAIT;
            dlg_pkg::S_VDWAIT: begin
                if (div_done) begin
                    state_next = dlg_pkg::S_VOLT;
                end
            end
            dlg_pkg::S_VOLT: begin
                // quotient never exceeds the 350 mV span
                cur_volt_next = dlg_pkg::VOLT_BASE
                              + dlg_pkg::VOLT_W'(div_quot[dlg_pkg::MUL_B_W-1:0]);
                state_next    = dlg_pkg::S_OUT;
            end
            dlg_pkg::S_OUT: begin
                // hold until the output word slot is free
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = dlg_pkg::S_IDLE;
                end
            end
            default: state_next = dlg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dlg_pkg::S_IDLE;
            min_reg      <= dlg_pkg::RST_MIN_FREQ;
            max_reg      <= dlg_pkg::RST_MAX_FREQ;
            cur_freq_reg <= dlg_pkg::RST_FREQ;
            cur_volt_reg <= dlg_pkg::RST_VOLT;
            count_reg    <= dlg_pkg::RST_COUNT;
            gov_reg      <= dlg_pkg::GOV_ONDEMAND;
            status_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_freq_reg <= cur_freq_next;
            cur_volt_reg <= cur_volt_next;
            count_reg    <= count_next;
            gov_reg      <= gov_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dlg_pkg::CFG_MIN_FREQ: min_reg <= cfg_data;
                    dlg_pkg::CFG_MAX_FREQ: max_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg <= tgt_next;
        if (in_accept) begin
            cmd_reg    <= s_cmd;
            load_reg   <= s_load_percent;
            greq_reg   <= s_governor_req;
            target_reg <= s_target_freq_khz;
        end
        if ((state_reg == dlg_pkg::S_IMUL) || (state_reg == dlg_pkg::S_VMUL)) begin
            prod_reg <= mul_p;
        end
        if (state_reg == dlg_pkg::S_IDIV) begin
            iq_reg <= iq_prod[dlg_pkg::RECIP_SHIFT +: dlg_pkg::FREQ_W];
        end
        if (out_load) begin
            m_freq_reg   <= cur_freq_reg;
            m_volt_reg   <= cur_volt_reg;
            m_count_reg  <= count_reg;
            m_gov_reg    <= gov_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_freq_khz        = m_freq_reg;
    assign m_volt_mv         = m_volt_reg;
    assign m_change_count    = m_count_reg;
    assign m_active_governor = m_gov_reg;
    assign m_status          = m_status_reg;

endmodule

`default_nettype wire

[design/dlg_checker.sv]
`default_nettype none

module dlg_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [dlg_pkg::FREQ_W-1:0]    m_freq_khz,
    input wire logic [dlg_pkg::VOLT_W-1:0]    m_volt_mv,
    input wire logic [dlg_pkg::GOV_W-1:0]     m_active_governor
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_freq_khz) && $stable(m_volt_mv))
        else $error("result word changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while a command is in progress");

    a_volt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_volt_mv >= dlg_pkg::VOLT_BASE)
                 && (m_volt_mv <= dlg_pkg::VOLT_BASE + dlg_pkg::VOLT_W'(dlg_pkg::VOLT_SPAN)))
        else $error("voltage outside the 850..1200 mV band");

    a_gov_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_active_governor <= dlg_pkg::GOV_LAST)
        else $error("active governor code out of range");

endmodule

bind dvfs_load_governor_unit dlg_checker u_dlg_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_freq_khz        (m_freq_khz),
    .m_volt_mv         (m_volt_mv),
    .m_active_governor (m_active_governor)
);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import dlg_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 155;

    localparam logic [GOV_W-1:0] GOV_CONSERVATIVE = 3'd3;
    localparam logic [GOV_W-1:0] GOV_SCHEDUTIL    = GOV_LAST;
    localparam logic             STAT_OK          = 1'b0;
    localparam logic             STAT_BAD_GOV     = 1'b1;

    localparam logic [FREQ_W-1:0] FREQ_TOP   = '1;
    localparam logic [FREQ_W-1:0] BOOT_FREQ  = 22'd2400000;
    localparam logic [FREQ_W-1:0] BOOT_LO    = 22'd800000;
    localparam logic [FREQ_W-1:0] BOOT_HI    = 22'd3600000;
    localparam logic [VOLT_W-1:0] BOOT_VOLT  = 11'd1050;
    localparam logic [CNT_W-1:0]  BOOT_COUNT = 32'd1;
    localparam logic [LOAD_W-1:0] BUSY_MARK  = 7'd75;
    localparam logic [LOAD_W-1:0] QUIET_MARK = 7'd25;
    localparam logic [LOAD_W-1:0] PERCENT    = 7'd100;
    localparam logic [VOLT_W-1:0] V_FLOOR    = 11'd850;
    localparam logic [8:0]        V_RANGE    = 9'd350;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [VOLT_W-1:0] volt;
        logic [CNT_W-1:0]  changes;
        logic [GOV_W-1:0]  gov;
        logic              status;
    } op_point_t;

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [FREQ_W-1:0]    cfg_data          = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd             = '0;
    logic [LOAD_W-1:0]    s_load_percent    = '0;
    logic [GOV_W-1:0]     s_governor_req    = '0;
    logic [FREQ_W-1:0]    s_target_freq_khz = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [FREQ_W-1:0]    m_freq_khz;
    logic [VOLT_W-1:0]    m_volt_mv;
    logic [CNT_W-1:0]     m_change_count;
    logic [GOV_W-1:0]     m_active_governor;
    logic                 m_status;

    // governor state as the block should hold it
    logic [FREQ_W-1:0] lim_lo, lim_hi, op_freq;
    logic [VOLT_W-1:0] op_volt;
    logic [CNT_W-1:0]  op_changes;
    logic [GOV_W-1:0]  op_gov;

    op_point_t readouts[$];
    int        errors      = 0;
    int        idle_pct    = 0;
    int        quiet_count = 0;
    int        stall_left  = 0;

    dvfs_load_governor_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_load_percent    (s_load_percent),
        .s_governor_req    (s_governor_req),
        .s_target_freq_khz (s_target_freq_khz),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_freq_khz        (m_freq_khz),
        .m_volt_mv         (m_volt_mv),
        .m_change_count    (m_change_count),
        .m_active_governor (m_active_governor),
        .m_status          (m_status)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void boot_governor();
        lim_lo     = BOOT_LO;
        lim_hi     = BOOT_HI;
        op_freq    = BOOT_FREQ;
        op_volt    = BOOT_VOLT;
        op_changes = BOOT_COUNT;
        op_gov     = GOV_ONDEMAND;
    endfunction

    // clamp low bound first, then high bound; only a real move touches volt and count
    function automatic void retarget(input logic [31:0] want);
        logic [31:0] t;
        logic [63:0] num;
        t = want;
        if (t < lim_lo) t = lim_lo;
        if (t > lim_hi) t = lim_hi;
        if (t != {10'd0, op_freq}) begin
            op_freq = t[FREQ_W-1:0];
            if (lim_hi > lim_lo) begin
                num = t - lim_lo;
                num = num * V_RANGE / (lim_hi - lim_lo);
                op_volt = V_FLOOR + num[VOLT_W-1:0];
            end else begin
                op_volt = V_FLOOR;
            end
            op_changes = op_changes + 1'b1;
        end
    endfunction

    function automatic op_point_t govern_step(input logic [CMD_W-1:0] cmd,
                                              input logic [LOAD_W-1:0] load,
                                              input logic [GOV_W-1:0] greq,
                                              input logic [FREQ_W-1:0] target);
        op_point_t r;
        logic      stat;
        logic [63:0] spread;
        stat = STAT_OK;
        case (cmd)
            CMD_LOAD: begin
                if (op_gov == GOV_ONDEMAND) begin
                    if (load > BUSY_MARK) begin
                        retarget(lim_hi);
                    end else if (load < QUIET_MARK) begin
                        retarget(lim_lo);
                    end else begin
                        spread = (lim_hi > lim_lo) ? lim_hi - lim_lo : 64'd0;
                        spread = spread * load / PERCENT;
                        retarget(lim_lo + spread[31:0]);
                    end
                end
            end
            CMD_GOV: begin
                if (greq > GOV_SCHEDUTIL) begin
                    stat = STAT_BAD_GOV;
                end else begin
                    op_gov = greq;
                    if (greq == GOV_PERF) retarget(lim_hi);
                    else if (greq == GOV_SAVE) retarget(lim_lo);
                end
            end
            CMD_FREQ: retarget(target);
            CMD_NONE: ;
        endcase
        r.freq    = op_freq;
        r.volt    = op_volt;
        r.changes = op_changes;
        r.gov     = op_gov;
        r.status  = stat;
        return r;
    endfunction

    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [LOAD_W-1:0] load,
                                 input logic [GOV_W-1:0] greq, input logic [FREQ_W-1:0] target);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= cmd;
        s_load_percent    <= load;
        s_governor_req    <= greq;
        s_target_freq_khz <= target;
        do @(posedge aclk); while (s_ready !== 1'b1);
        readouts.push_back(govern_step(cmd, load, greq, target));
    endtask

    // order: 0 min then max, 1 max then min, 2 min only, 3 max only
    task automatic program_range(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
                                 input int order);
        logic [CFG_IDX_W-1:0] idx[$];
        logic [FREQ_W-1:0]    val[$];
        if (order != 3) begin
            idx.push_back(CFG_MIN_FREQ);
            val.push_back(lo);
        end
        if (order != 2) begin
            if (order == 1) begin
                idx.push_front(CFG_MAX_FREQ);
                val.push_front(hi);
            end else begin
                idx.push_back(CFG_MAX_FREQ);
                val.push_back(hi);
            end
        end
        s_valid <= 1'b0;
        while (readouts.size() != 0) @(posedge aclk);
        foreach (idx[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            if (idx[i] == CFG_MIN_FREQ) lim_lo = val[i];
            else lim_hi = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        op_point_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (readouts.size() == 0) begin
                $error("result word with nothing pending: freq %0d", m_freq_khz);
                errors++;
            end else begin
                want = readouts.pop_front();
                check_field("freq_khz", want.freq, m_freq_khz);
                check_field("volt_mv", want.volt, m_volt_mv);
                check_field("change_count", want.changes, m_change_count);
                check_field("active_governor", want.gov, m_active_governor);
                check_field("status", want.status, m_status);
            end
        end
    end

    // result side back-pressure in short bursts
    always @(posedge aclk) begin
        if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_count <= 0;
        end else if (quiet_count == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic test_boot_state;
        logic [LOAD_W-1:0] marks[7];
        marks = '{7'd0, 7'd24, 7'd25, 7'd50, 7'd75, 7'd76, 7'd127};
        issue_command(CMD_NONE, '1, '1, FREQ_TOP);
        foreach (marks[i])
            issue_command(CMD_LOAD, marks[i], 3'($urandom), 22'($urandom));
    endtask

    task automatic test_governor_switch;
        issue_command(CMD_GOV, 7'd0, 3'd7, '0);
        issue_command(CMD_GOV, 7'd0, GOV_CONSERVATIVE, '0);
        // load samples are ignored outside ondemand
        issue_command(CMD_LOAD, 7'd100, '0, '0);
        issue_command(CMD_GOV, 7'd0, GOV_SCHEDUTIL, '0);
        issue_command(CMD_GOV, 7'd0, GOV_PERF, '0);
        issue_command(CMD_GOV, 7'd0, GOV_SAVE, '0);
        issue_command(CMD_GOV, 7'd0, 3'd5, '0);
        issue_command(CMD_GOV, 7'd0, GOV_ONDEMAND, '0);
    endtask

    task automatic test_frequency_requests;
        issue_command(CMD_FREQ, '0, '0, '0);
        issue_command(CMD_FREQ, '1, '1, FREQ_TOP);
        issue_command(CMD_FREQ, '0, '0, 22'd1234567);
        // same target again: no transition
        issue_command(CMD_FREQ, '0, '0, 22'd1234567);
    endtask

    task automatic test_range_corners;
        program_range(22'd1000000, 22'd1000000, 0);
        issue_command(CMD_LOAD, 7'd50, '0, '0);
        issue_command(CMD_FREQ, '0, '0, 22'd2000000);
        // inverted range: clamping ends on max
        program_range(FREQ_TOP, 22'd0, 1);
        issue_command(CMD_FREQ, '0, '0, 22'd12345);
        issue_command(CMD_LOAD, 7'd60, '0, '0);
        program_range(22'd0, FREQ_TOP, 0);
        issue_command(CMD_LOAD, 7'd76, '0, '0);
        issue_command(CMD_LOAD, 7'd50, '0, '0);
    endtask

    task automatic random_command;
        logic [CMD_W-1:0]  cmd;
        logic [LOAD_W-1:0] load;
        logic [GOV_W-1:0]  greq;
        logic [FREQ_W-1:0] target, a, b;
        logic [LOAD_W-1:0] load_marks[9];
        int                pick;
        load_marks = '{7'd0, 7'd24, 7'd25, 7'd26, 7'd74, 7'd75, 7'd76, 7'd100, 7'd127};
        pick = $urandom_range(0, 99);
        cmd  = (pick < 45) ? CMD_LOAD : (pick < 65) ? CMD_GOV : (pick < 92) ? CMD_FREQ : CMD_NONE;
        load = ($urandom_range(0, 9) < 7) ? 7'($urandom) : load_marks[$urandom_range(0, 8)];
        // lean toward ondemand so load samples keep doing work
        greq = ($urandom_range(0, 9) < 6) ? GOV_ONDEMAND : 3'($urandom);
        a    = (lim_lo < lim_hi) ? lim_lo : lim_hi;
        b    = (lim_lo < lim_hi) ? lim_hi : lim_lo;
        case ($urandom_range(0, 4))
            0: target = 22'($urandom);
            1: target = lim_lo;
            2: target = lim_hi;
            3: target = op_freq;
            default: target = 22'($urandom_range(b, a));
        endcase
        issue_command(cmd, load, greq, target);
    endtask

    task automatic test_random_traffic;
        logic [FREQ_W-1:0] lo, hi;
        int                order;
        int                pct_choices[4];
        pct_choices = '{0, 10, 25, 50};
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p >= PHASES - 2) ? 0 : pct_choices[$urandom_range(0, 3)];
            case ($urandom_range(0, 5))
                0: begin lo = BOOT_LO; hi = BOOT_HI; end
                1: begin lo = '0; hi = FREQ_TOP; end
                2: begin lo = 22'($urandom); hi = lo; end
                3: begin lo = FREQ_TOP; hi = '0; end
                4: begin lo = 22'($urandom); hi = 22'($urandom); end
                default: begin
                    lo = 22'($urandom_range(0, 3000000));
                    hi = lo + 22'($urandom_range(1, FREQ_TOP - lo));
                end
            endcase
            order = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
            program_range(lo, hi, order);
            repeat (PHASE_WORDS) random_command();
        end
    endtask

    initial begin
        boot_governor();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_pct = 20;
        test_boot_state();
        test_governor_switch();
        test_frequency_requests();
        test_range_corners();
        test_random_traffic();
        s_valid <= 1'b0;
        while (readouts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/dlg_pkg.sv
design/dlg_div.sv
design/dvfs_load_governor_unit.sv
design/dlg_checker.sv
bench/tb.sv
